// ===== design/rgb2yuv_pkg.sv =====
// Shared types and constants for the RGB to 4:2:0 YCbCr quad converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package rgb2yuv_pkg;

  // Default number of fractional bits of the fixed-point coefficients
  localparam int unsigned COEF_FRAC_BITS_DEF = 16;

  // Colour matrix codes held in the configuration register
  localparam logic MATRIX_BT601 = 1'b0;
  localparam logic MATRIX_BT709 = 1'b1;
  localparam logic MATRIX_RESET = MATRIX_BT709;

  // Luma weights in units of 1/10000
  localparam longint unsigned KR_601 = 2990;
  localparam longint unsigned KG_601 = 5870;
  localparam longint unsigned KB_601 = 1140;
  localparam longint unsigned KR_709 = 2126;
  localparam longint unsigned KG_709 = 7152;
  localparam longint unsigned KB_709 = 722;

  // Scale factors of the limited-range conversion
  localparam longint unsigned LUMA_SPAN   = 219;
  localparam longint unsigned CHROMA_SPAN = 224;
  localparam longint unsigned FULL_SPAN   = 255;
  localparam longint unsigned WEIGHT_ONE  = 10000;
  // Offsets in half units: 16.5 and 128.5
  localparam int unsigned LUMA_OFF_HALVES   = 33;
  localparam int unsigned CHROMA_OFF_HALVES = 257;

  localparam int unsigned NUM_LANES = 4;

  typedef logic [23:0] pixel_t;
  typedef logic [7:0]  sample_t;

  typedef struct packed {
    pixel_t pixel_top_left;
    pixel_t pixel_top_right;
    pixel_t pixel_bottom_left;
    pixel_t pixel_bottom_right;
    logic   last_quad;
  } pix_quad_t;

  typedef struct packed {
    sample_t luma_top_left;
    sample_t luma_top_right;
    sample_t luma_bottom_left;
    sample_t luma_bottom_right;
    sample_t chroma_blue;
    sample_t chroma_red;
    logic    frame_end;
  } yuv_quad_t;

  // Per-pixel result of one lane
  typedef struct packed {
    sample_t y;
    sample_t cb;
    sample_t cr;
  } lane_res_t;

  // Stage enables driven by the pipeline control
  typedef struct packed {
    logic adv_a;
    logic adv_b;
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== design/rgb2yuv_lane.sv =====
// One pixel lane: nine coefficient products, then sums, offsets and clamps.
// Depends on rgb2yuv_pkg.
`default_nettype none

module rgb2yuv_lane #(
  parameter int unsigned COEF_FRAC_BITS = rgb2yuv_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire                       clk_i,
  input  rgb2yuv_pkg::lane_ctl_t    ctl_i,
  input  wire                       matrix_sel_i,
  input  rgb2yuv_pkg::pixel_t       pixel_i,
  output rgb2yuv_pkg::lane_res_t    res_o
);
  import rgb2yuv_pkg::*;

  localparam int unsigned F  = COEF_FRAC_BITS;
  localparam int unsigned PW = F + 8;   // product width
  localparam int unsigned SW = F + 11;  // signed sum width

  localparam longint unsigned ONE   = 64'd1 << F;
  localparam longint unsigned DEN_Y = FULL_SPAN * WEIGHT_ONE;
  localparam longint unsigned DEN_B_601 = 2 * (WEIGHT_ONE - KB_601) * FULL_SPAN;
  localparam longint unsigned DEN_B_709 = 2 * (WEIGHT_ONE - KB_709) * FULL_SPAN;
  localparam longint unsigned DEN_R_601 = 2 * (WEIGHT_ONE - KR_601) * FULL_SPAN;
  localparam longint unsigned DEN_R_709 = 2 * (WEIGHT_ONE - KR_709) * FULL_SPAN;

  // Coefficient magnitudes, rounded half up; signs are fixed by position
  localparam longint unsigned YR_601 = (KR_601 * LUMA_SPAN * ONE + DEN_Y / 2) / DEN_Y;
  localparam longint unsigned YG_601 = (KG_601 * LUMA_SPAN * ONE + DEN_Y / 2) / DEN_Y;
  localparam longint unsigned YB_601 = (KB_601 * LUMA_SPAN * ONE + DEN_Y / 2) / DEN_Y;
  localparam longint unsigned YR_709 = (KR_709 * LUMA_SPAN * ONE + DEN_Y / 2) / DEN_Y;
  localparam longint unsigned YG_709 = (KG_709 * LUMA_SPAN * ONE + DEN_Y / 2) / DEN_Y;
  localparam longint unsigned YB_709 = (KB_709 * LUMA_SPAN * ONE + DEN_Y / 2) / DEN_Y;
  localparam longint unsigned BR_601 =
      (KR_601 * CHROMA_SPAN * ONE + DEN_B_601 / 2) / DEN_B_601;
  localparam longint unsigned BG_601 =
      (KG_601 * CHROMA_SPAN * ONE + DEN_B_601 / 2) / DEN_B_601;
  localparam longint unsigned BR_709 =
      (KR_709 * CHROMA_SPAN * ONE + DEN_B_709 / 2) / DEN_B_709;
  localparam longint unsigned BG_709 =
      (KG_709 * CHROMA_SPAN * ONE + DEN_B_709 / 2) / DEN_B_709;
  localparam longint unsigned RG_601 =
      (KG_601 * CHROMA_SPAN * ONE + DEN_R_601 / 2) / DEN_R_601;
  localparam longint unsigned RB_601 =
      (KB_601 * CHROMA_SPAN * ONE + DEN_R_601 / 2) / DEN_R_601;
  localparam longint unsigned RG_709 =
      (KG_709 * CHROMA_SPAN * ONE + DEN_R_709 / 2) / DEN_R_709;
  localparam longint unsigned RB_709 =
      (KB_709 * CHROMA_SPAN * ONE + DEN_R_709 / 2) / DEN_R_709;
  localparam longint unsigned HALF_C = (112 * ONE + FULL_SPAN / 2) / FULL_SPAN;

  localparam logic [63:0] HALF_C_V = 64'(HALF_C);
  localparam logic [63:0] YR601_V = 64'(YR_601);
  localparam logic [63:0] YG601_V = 64'(YG_601);
  localparam logic [63:0] YB601_V = 64'(YB_601);
  localparam logic [63:0] YR709_V = 64'(YR_709);
  localparam logic [63:0] YG709_V = 64'(YG_709);
  localparam logic [63:0] YB709_V = 64'(YB_709);
  localparam logic [63:0] BR601_V = 64'(BR_601);
  localparam logic [63:0] BG601_V = 64'(BG_601);
  localparam logic [63:0] BR709_V = 64'(BR_709);
  localparam logic [63:0] BG709_V = 64'(BG_709);
  localparam logic [63:0] RG601_V = 64'(RG_601);
  localparam logic [63:0] RB601_V = 64'(RB_601);
  localparam logic [63:0] RG709_V = 64'(RG_709);
  localparam logic [63:0] RB709_V = 64'(RB_709);

  localparam logic [SW-1:0] Y_OFF = SW'(LUMA_OFF_HALVES) << (F - 1);
  localparam logic [SW-1:0] C_OFF = SW'(CHROMA_OFF_HALVES) << (F - 1);

  logic [7:0]   r, g, b;
  logic [F-1:0] c_yr, c_yg, c_yb, c_br, c_bg, c_rg, c_rb, c_half;

  logic [PW-1:0] p_yr_q, p_yg_q, p_yb_q;
  logic [PW-1:0] p_br_q, p_bg_q, p_bb_q;
  logic [PW-1:0] p_rr_q, p_rg_q, p_rb_q;

  logic [SW-1:0] s_y, s_cb, s_cr;
  lane_res_t     res_d, res_q;

  // Shift out the sign check and the integer part, saturate to a byte
  function automatic sample_t clamp_sum(input logic [SW-1:0] s);
    sample_t v;
    if (s[SW-1]) begin
      v = '0;
    end else if (|s[SW-2:F+8]) begin
      v = '1;
    end else begin
      v = s[F+7:F];
    end
    return v;
  endfunction

  assign r = pixel_i[23:16];
  assign g = pixel_i[15:8];
  assign b = pixel_i[7:0];

  // Pick the coefficient set of the selected matrix
  always_comb begin
    c_half = HALF_C_V[F-1:0];
    if (matrix_sel_i == MATRIX_BT601) begin
      c_yr = YR601_V[F-1:0];
      c_yg = YG601_V[F-1:0];
      c_yb = YB601_V[F-1:0];
      c_br = BR601_V[F-1:0];
      c_bg = BG601_V[F-1:0];
      c_rg = RG601_V[F-1:0];
      c_rb = RB601_V[F-1:0];
    end else begin
      c_yr = YR709_V[F-1:0];
      c_yg = YG709_V[F-1:0];
      c_yb = YB709_V[F-1:0];
      c_br = BR709_V[F-1:0];
      c_bg = BG709_V[F-1:0];
      c_rg = RG709_V[F-1:0];
      c_rb = RB709_V[F-1:0];
    end
  end

  // Stage A: register the nine products
  always_ff @(posedge clk_i) begin
    if (ctl_i.adv_a) begin
      p_yr_q <= PW'(r) * PW'(c_yr);
      p_yg_q <= PW'(g) * PW'(c_yg);
      p_yb_q <= PW'(b) * PW'(c_yb);
      p_br_q <= PW'(r) * PW'(c_br);
      p_bg_q <= PW'(g) * PW'(c_bg);
      p_bb_q <= PW'(b) * PW'(c_half);
      p_rr_q <= PW'(r) * PW'(c_half);
      p_rg_q <= PW'(g) * PW'(c_rg);
      p_rb_q <= PW'(b) * PW'(c_rb);
    end
  end

  // Stage B: signed sums with offsets, then clamp
  always_comb begin
    s_y  = Y_OFF + SW'(p_yr_q) + SW'(p_yg_q) + SW'(p_yb_q);
    s_cb = C_OFF + SW'(p_bb_q) - SW'(p_br_q) - SW'(p_bg_q);
    s_cr = C_OFF + SW'(p_rr_q) - SW'(p_rg_q) - SW'(p_rb_q);
    res_d.y  = clamp_sum(s_y);
    res_d.cb = clamp_sum(s_cb);
    res_d.cr = clamp_sum(s_cr);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv_b) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== design/rgb2yuv_merge.sv =====
// Merging stage: averages the four lanes' chroma and holds the output transaction.
// Depends on rgb2yuv_pkg.
`default_nettype none

module rgb2yuv_merge (
  input  wire                    clk_i,
  input  wire                    load_i,
  input  rgb2yuv_pkg::lane_res_t lane_i [rgb2yuv_pkg::NUM_LANES],
  input  wire                    last_i,
  output rgb2yuv_pkg::yuv_quad_t data_o
);
  import rgb2yuv_pkg::*;

  logic [9:0] sum_cb, sum_cr;
  yuv_quad_t  data_d, data_q;

  // Round the four-sample averages half up
  always_comb begin
    sum_cb = 10'(lane_i[0].cb) + 10'(lane_i[1].cb) + 10'(lane_i[2].cb)
           + 10'(lane_i[3].cb) + 10'd2;
    sum_cr = 10'(lane_i[0].cr) + 10'(lane_i[1].cr) + 10'(lane_i[2].cr)
           + 10'(lane_i[3].cr) + 10'd2;
    data_d.luma_top_left     = lane_i[0].y;
    data_d.luma_top_right    = lane_i[1].y;
    data_d.luma_bottom_left  = lane_i[2].y;
    data_d.luma_bottom_right = lane_i[3].y;
    data_d.chroma_blue       = sum_cb[9:2];
    data_d.chroma_red        = sum_cr[9:2];
    data_d.frame_end         = last_i;
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== design/rgb_to_yuv420_quad_converter_core.sv =====
// RGB to 4:2:0 limited-range YCbCr quad converter, top level.
// Depends on rgb2yuv_pkg, rgb2yuv_lane and rgb2yuv_merge.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one 2x2 quad of
//   8-bit RGB pixels plus a frame marker. Output channel
//   (out_valid_o/out_ready_i/out_data_o) returns four luma samples, the
//   averaged Cb/Cr pair and the frame marker, one transaction per quad.
//   cfg_we_i/cfg_wdata_i write the matrix select (0 = BT.601, 1 = BT.709);
//   write it only while no quad is in flight.
// Pipeline: the product stage, then the sum/clamp stage, then the chroma
//   merge into the output register that drives output valid.
// Throughput: one quad per cycle when not stalled; four pixel lanes run
//   in parallel, each with nine small multipliers in its product stage.
// Reset: all stages empty, output invalid, matrix select set to BT.709.
// Stall: each stage advances when the next one is empty or draining, so a
//   blocked receiver fills bubbles first; in_ready_o drops only once all
//   three stages hold quads and out_ready_i is low.
`default_nettype none

module rgb_to_yuv420_quad_converter_core #(
  parameter int unsigned COEF_FRAC_BITS = rgb2yuv_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire                    cfg_wdata_i,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  rgb2yuv_pkg::pix_quad_t in_data_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output rgb2yuv_pkg::yuv_quad_t out_data_o
);
  import rgb2yuv_pkg::*;

  logic      matrix_q;
  logic      va_q, vb_q, vo_q;
  logic      last_a_q, last_b_q;
  logic      free_b, free_o, adv_o;
  lane_ctl_t ctl;
  pixel_t    px [NUM_LANES];
  lane_res_t res [NUM_LANES];

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_q <= MATRIX_RESET;
    end else if (cfg_we_i) begin
      matrix_q <= cfg_wdata_i;
    end
  end

  // Stage handshakes
  assign free_o     = !vo_q || out_ready_i;
  assign adv_o      = vb_q && free_o;
  assign free_b     = !vb_q || adv_o;
  assign ctl.adv_b  = va_q && free_b;
  assign in_ready_o = !va_q || free_b;
  assign ctl.adv_a  = in_valid_i && in_ready_o;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (ctl.adv_a) begin
        va_q <= 1'b1;
      end else if (ctl.adv_b) begin
        va_q <= 1'b0;
      end
      if (ctl.adv_b) begin
        vb_q <= 1'b1;
      end else if (adv_o) begin
        vb_q <= 1'b0;
      end
      if (adv_o) begin
        vo_q <= 1'b1;
      end else if (out_ready_i) begin
        vo_q <= 1'b0;
      end
    end
  end

  // Carry the frame marker alongside the lanes
  always_ff @(posedge clk_i) begin
    if (ctl.adv_a) begin
      last_a_q <= in_data_i.last_quad;
    end
    if (ctl.adv_b) begin
      last_b_q <= last_a_q;
    end
  end

  assign px[0] = in_data_i.pixel_top_left;
  assign px[1] = in_data_i.pixel_top_right;
  assign px[2] = in_data_i.pixel_bottom_left;
  assign px[3] = in_data_i.pixel_bottom_right;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    rgb2yuv_lane #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_lane (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .matrix_sel_i(matrix_q),
      .pixel_i     (px[i]),
      .res_o       (res[i])
    );
  end

  rgb2yuv_merge u_merge (
    .clk_i (clk_i),
    .load_i(adv_o),
    .lane_i(res),
    .last_i(last_b_q),
    .data_o(out_data_o)
  );

  assign out_valid_o = vo_q;

endmodule

`default_nettype wire

// ===== design/rgb2yuv_chk.sv =====
// Port-level checker for the quad converter, bound to the top level.
// Depends on rgb2yuv_pkg and rgb_to_yuv420_quad_converter_core.
`default_nettype none

module rgb2yuv_chk (
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    in_valid_i,
  input wire                    in_ready_o,
  input wire                    out_valid_o,
  input wire                    out_ready_i,
  input rgb2yuv_pkg::yuv_quad_t out_data_o
);
  import rgb2yuv_pkg::*;

  logic [2:0] inflight_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Count quads accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - 3'd1;
    end
  end

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // No result without a quad behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 3'd0)
    else $error("result with nothing in flight");

  // Pipeline holds at most three quads
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd3)
    else $error("more quads in flight than stages");

  // Input backs off only under output back-pressure
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && inflight_q == 3'd3)
    else $error("input stalled with room in the pipeline");

endmodule

bind rgb_to_yuv420_quad_converter_core rgb2yuv_chk u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire
